// File: design/fzn_pkg.sv
// ----------------------------------------------------------------------------
// Feature z-score normalizer package
// Field widths, operation and status codes, and shared types of the block.
// ----------------------------------------------------------------------------
package fzn_pkg;

   localparam int OP_W      = 2;
   localparam int ELEM_W    = 6;
   localparam int VALUE_W   = 24;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 13;
   localparam int CSR_W     = 7;
   localparam int SUM_W     = 36;
   localparam int SQSUM_W   = 60;
   localparam int MAX_ITEMS = 4096;
   localparam int EIU_RESET = 64;

   localparam int DIV_NUM_W = 60;
   localparam int DIV_DEN_W = 24;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
   localparam int SQRT_W    = 62;
   localparam int ROOT_W    = 31;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 24'sh7FFFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 24'sh800000;

   typedef enum logic [OP_W-1:0] {
      OP_ACCUMULATE  = 2'd0,
      OP_FINALIZE    = 2'd1,
      OP_NORMALIZE   = 2'd2,
      OP_DENORMALIZE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_READY = 2'd1,
      STATUS_SATURATED = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      sat;
   } sat_type;

endpackage

// File: design/fzn_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one input transaction to the normalizer.
// ----------------------------------------------------------------------------
interface fzn_req_if;
   import fzn_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [ELEM_W-1:0]   element;
   logic [VALUE_W-1:0]  value;
   logic                apply;
   logic                first_item;
   logic                last_of_item;

   modport source (output valid, operation, element, value, apply, first_item,
                   last_of_item, input ready);
   modport sink (input valid, operation, element, value, apply, first_item,
                 last_of_item, output ready);
endinterface

// File: design/fzn_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result transaction from the normalizer.
// ----------------------------------------------------------------------------
interface fzn_rsp_if;
   import fzn_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  result_value;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  item_count;

   modport source (output valid, result_value, status, item_count, input ready);
   modport sink (input valid, result_value, status, item_count, output ready);
endinterface

// File: design/fzn_divider.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fzn_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fzn_pkg::DIV_NUM_W-1:0]   numerator,
   input  logic [fzn_pkg::DIV_DEN_W-1:0]   denominator,
   output logic                            done,
   output logic [fzn_pkg::DIV_NUM_W-1:0]   quotient
);
   import fzn_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  count_ff;
   logic [DIV_DEN_W-1:0]  rem_ff;
   logic [DIV_DEN_W-1:0]  den_ff;
   logic [DIV_NUM_W-1:0]  quo_ff;
   logic [DIV_DEN_W:0]    trial;
   logic [DIV_DEN_W:0]    trial_diff;
   logic                  fits;

   assign trial      = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && count_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff   <= numerator;
         den_ff   <= denominator;
         rem_ff   <= '0;
         count_ff <= '0;
      end else if (busy_ff) begin
         rem_ff   <= fits ? trial_diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_ff   <= {quo_ff[DIV_NUM_W-2:0], fits};
         count_ff <= count_ff + DIV_CNT_W'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: design/fzn_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fzn_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fzn_pkg::SQRT_W-1:0]   radicand,
   output logic                         done,
   output logic [fzn_pkg::ROOT_W-1:0]   root
);
   import fzn_pkg::*;

   localparam logic [SQRT_W-1:0] FIRST_BIT = SQRT_W'(1) << (SQRT_W - 2);

   logic              busy_ff;
   logic              done_ff;
   logic [SQRT_W-1:0] rad_ff;
   logic [SQRT_W-1:0] root_ff;
   logic [SQRT_W-1:0] bit_ff;
   logic [SQRT_W-1:0] trial;
   logic              fits;

   assign trial = root_ff + bit_ff;
   assign fits  = rad_ff >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         root_ff <= '0;
         bit_ff  <= FIRST_BIT;
      end else if (busy_ff) begin
         if (fits) begin
            rad_ff  <= rad_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = root_ff[ROOT_W-1:0];
endmodule

// File: design/feature_zscore_normalizer_top.sv
// ----------------------------------------------------------------------------
// Feature z-score normalizer
// Sequencing: accumulate squares the value and then writes the sums; denormalize
// multiplies and then adds; normalize runs one division; finalize runs, per element in
// use, three divisions (two with a single item) and a square root.
// Throughput: one transaction at a time; the iterative divider and square root set the rate.
// Reset: control, item count and ready flag clear, elements_in_use becomes 64;
// the statistics memories are not cleared.
// ----------------------------------------------------------------------------
module feature_zscore_normalizer_top #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   fzn_req_if.sink                       req_chan,
   fzn_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [fzn_pkg::CSR_W-1:0]     csr_wr_data
);
   import fzn_pkg::*;

   localparam int AW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW   = $clog2(MAX_ELEMENTS + 1);
   localparam int MA_W = SUM_W + SQSUM_W;
   localparam int MB_W = 2 * VALUE_W;
   localparam logic [DIV_NUM_W-1:0] MAG_MAX = DIV_NUM_W'(8388607);
   localparam logic [DIV_NUM_W-1:0] MAG_MIN = DIV_NUM_W'(8388608);

   typedef enum logic [16:0] {
      ST_IDLE       = 17'h00001,
      ST_ACC_SQ     = 17'h00002,
      ST_ACC_WR     = 17'h00004,
      ST_FIN_RD     = 17'h00008,
      ST_FIN_MEAN_S = 17'h00010,
      ST_FIN_MEAN_W = 17'h00020,
      ST_FIN_E2_S   = 17'h00040,
      ST_FIN_E2_W   = 17'h00080,
      ST_FIN_VAR_S  = 17'h00100,
      ST_FIN_VAR_W  = 17'h00200,
      ST_FIN_SQRT_S = 17'h00400,
      ST_FIN_SQRT_W = 17'h00800,
      ST_NRM_S      = 17'h01000,
      ST_NRM_W      = 17'h02000,
      ST_DEN_MUL    = 17'h04000,
      ST_DEN_ADD    = 17'h08000,
      ST_OUT        = 17'h10000
   } state_type;

   function automatic sat_type sat_mag(input logic neg, input logic [DIV_NUM_W-1:0] mag);
      sat_type r;
      r.sat = 1'b0;
      if (neg) begin
         if (mag > MAG_MIN) begin
            r.value = VALUE_MIN;
            r.sat   = 1'b1;
         end else begin
            r.value = $signed(VALUE_W'(0) - mag[VALUE_W-1:0]);
         end
      end else if (mag > MAG_MAX) begin
         r.value = VALUE_MAX;
         r.sat   = 1'b1;
      end else begin
         r.value = $signed(mag[VALUE_W-1:0]);
      end
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [CSR_W-1:0]     eiu_ff;
   logic [COUNT_W-1:0]   items_ff;
   logic                 stats_ready_ff;

   op_type               op_ff;
   logic [ELEM_W-1:0]    el_ff;
   logic [VALUE_W-1:0]   x_ff;
   logic                 first_ff;
   logic                 last_ff;

   logic [VALUE_W-1:0]   res_ff;
   status_type           status_ff;
   logic [CW-1:0]        cnt_ff;
   logic [CW-1:0]        limit_ff;
   logic                 sat_ff;
   logic                 neg_ff;
   logic [VALUE_W-1:0]   mean_ff;
   logic [2*VALUE_W-1:0] sq_ff;
   logic [2*VALUE_W-1:0] msq_ff;
   logic [SQSUM_W-1:0]   diff_ff;
   logic [SQRT_W-1:0]    var_ff;
   logic signed [48:0]   p_ff;

   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic [MA_W-1:0]      ma_mem [MAX_ELEMENTS];
   logic [MB_W-1:0]      mb_mem [MAX_ELEMENTS];
   logic [MA_W-1:0]      ma_rd_ff;
   logic [MB_W-1:0]      mb_rd_ff;
   logic [AW-1:0]        rd_addr;

   op_type               req_op;
   logic                 req_oob;
   logic                 items_full;
   logic [CW-1:0]        limit_in;
   logic                 rsp_load;

   logic [SUM_W-1:0]     sum_rd;
   logic [SQSUM_W-1:0]   sqsum_rd;
   logic [SUM_W-1:0]     x_ext;
   logic [VALUE_W-1:0]   x_mag;
   logic [SUM_W-1:0]     sum_mag;
   logic [VALUE_W-1:0]   mean_mag;
   logic [VALUE_W-1:0]   mb_mean;
   logic [VALUE_W-1:0]   mb_sd;
   logic [VALUE_W-1:0]   sd_safe;
   logic [VALUE_W:0]     nrm_d;
   logic [VALUE_W:0]     nrm_mag;
   logic [COUNT_W-1:0]   items_base;
   logic [COUNT_W-1:0]   items_upd;
   logic [SQSUM_W-1:0]   e2_diff;
   logic [48:0]          p_mag;
   logic [48:0]          p_round;
   logic signed [38:0]   den_q;
   logic signed [38:0]   den_total;
   logic                 fin_last;
   logic                 sd_sat;
   logic [VALUE_W-1:0]   sd_val;
   sat_type              mean_sat;
   sat_type              nrm_sat;

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;
   logic                 sqrt_start;
   logic                 sqrt_done;
   logic [ROOT_W-1:0]    sqrt_root;

   assign req_op     = op_type'(req_chan.operation);
   assign req_oob    = 32'(req_chan.element) >= MAX_ELEMENTS;
   assign items_full = items_ff == COUNT_W'(MAX_ITEMS);
   assign limit_in   = (32'(eiu_ff) > MAX_ELEMENTS) ? CW'(MAX_ELEMENTS) : CW'(eiu_ff);
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_addr = AW'(req_chan.element);
      end else if (op_ff == OP_FINALIZE) begin
         rd_addr = cnt_ff[AW-1:0];
      end else begin
         rd_addr = AW'(el_ff);
      end
   end

   always_ff @(posedge clock) begin
      ma_rd_ff <= ma_mem[rd_addr];
      mb_rd_ff <= mb_mem[rd_addr];
      if (state_ff == ST_ACC_WR) begin
         ma_mem[AW'(el_ff)] <= {first_ff ? x_ext : sum_rd + x_ext,
                                first_ff ? SQSUM_W'(sq_ff) : sqsum_rd + SQSUM_W'(sq_ff)};
      end
      if (state_ff == ST_FIN_SQRT_W && sqrt_done) begin
         mb_mem[cnt_ff[AW-1:0]] <= {mean_ff, sd_val};
      end
   end

   assign sum_rd   = ma_rd_ff[MA_W-1 -: SUM_W];
   assign sqsum_rd = ma_rd_ff[SQSUM_W-1:0];
   assign mb_mean  = mb_rd_ff[MB_W-1 -: VALUE_W];
   assign mb_sd    = mb_rd_ff[VALUE_W-1:0];

   assign x_ext    = {{(SUM_W - VALUE_W){x_ff[VALUE_W-1]}}, x_ff};
   assign x_mag    = x_ff[VALUE_W-1] ? VALUE_W'(0) - x_ff : x_ff;
   assign sum_mag  = sum_rd[SUM_W-1] ? SUM_W'(0) - sum_rd : sum_rd;
   assign mean_mag = mean_ff[VALUE_W-1] ? VALUE_W'(0) - mean_ff : mean_ff;
   assign sd_safe  = (mb_sd == '0) ? VALUE_W'(1) : mb_sd;
   assign nrm_d    = {x_ff[VALUE_W-1], x_ff} - {mb_mean[VALUE_W-1], mb_mean};
   assign nrm_mag  = nrm_d[VALUE_W] ? (VALUE_W+1)'(0) - nrm_d : nrm_d;

   assign items_base = first_ff ? '0 : items_ff;
   assign items_upd  = items_base +
                       COUNT_W'(last_ff && items_base < COUNT_W'(MAX_ITEMS));

   assign e2_diff  = (div_quo > SQSUM_W'(msq_ff)) ? div_quo - SQSUM_W'(msq_ff) : '0;
   assign fin_last = (cnt_ff + CW'(1)) == limit_ff;
   assign sd_sat   = sqrt_root > ROOT_W'(8388607);
   assign sd_val   = sd_sat ? VALUE_W'(8388607) : sqrt_root[VALUE_W-1:0];
   assign mean_sat = sat_mag(neg_ff, div_quo);
   assign nrm_sat  = sat_mag(neg_ff, div_quo);

   assign p_mag     = p_ff[48] ? 49'd0 - p_ff : p_ff;
   assign p_round   = p_mag + 49'd2048;
   assign den_q     = p_ff[48] ? -$signed({2'b00, p_round[48:12]})
                               : $signed({2'b00, p_round[48:12]});
   assign den_total = den_q + $signed({{15{mean_ff[VALUE_W-1]}}, mean_ff});

   always_comb begin
      div_start = 1'b1;
      div_num   = '0;
      div_den   = DIV_DEN_W'(items_ff);
      case (state_ff)
         ST_FIN_MEAN_S: div_num = DIV_NUM_W'(sum_mag) + DIV_NUM_W'(items_ff >> 1);
         ST_FIN_E2_S:   div_num = sqsum_rd;
         ST_FIN_VAR_S: begin
            div_num = diff_ff;
            div_den = DIV_DEN_W'(items_ff - COUNT_W'(1));
         end
         ST_NRM_S: begin
            div_num = DIV_NUM_W'({nrm_mag, 12'b0}) + DIV_NUM_W'(sd_safe >> 1);
            div_den = sd_safe;
         end
         default: div_start = 1'b0;
      endcase
   end

   assign sqrt_start = state_ff == ST_FIN_SQRT_S;

   fzn_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_quo)
   );

   fzn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (var_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_op)
                  OP_ACCUMULATE: begin
                     state_in = (req_oob || (!req_chan.first_item && items_full))
                                ? ST_OUT : ST_ACC_SQ;
                  end
                  OP_FINALIZE: begin
                     state_in = (items_ff == '0 || limit_in == '0) ? ST_OUT : ST_FIN_RD;
                  end
                  default: begin
                     if (!req_chan.apply || !stats_ready_ff || req_oob) begin
                        state_in = ST_OUT;
                     end else if (req_op == OP_NORMALIZE) begin
                        state_in = ST_NRM_S;
                     end else begin
                        state_in = ST_DEN_MUL;
                     end
                  end
               endcase
            end
         end
         ST_ACC_SQ:     state_in = ST_ACC_WR;
         ST_ACC_WR:     state_in = ST_OUT;
         ST_FIN_RD:     state_in = ST_FIN_MEAN_S;
         ST_FIN_MEAN_S: state_in = ST_FIN_MEAN_W;
         ST_FIN_MEAN_W: if (div_done) state_in = ST_FIN_E2_S;
         ST_FIN_E2_S:   state_in = ST_FIN_E2_W;
         ST_FIN_E2_W: begin
            if (div_done) begin
               state_in = (items_ff == COUNT_W'(1)) ? ST_FIN_SQRT_S : ST_FIN_VAR_S;
            end
         end
         ST_FIN_VAR_S:  state_in = ST_FIN_VAR_W;
         ST_FIN_VAR_W:  if (div_done) state_in = ST_FIN_SQRT_S;
         ST_FIN_SQRT_S: state_in = ST_FIN_SQRT_W;
         ST_FIN_SQRT_W: if (sqrt_done) state_in = fin_last ? ST_OUT : ST_FIN_RD;
         ST_NRM_S:      state_in = ST_NRM_W;
         ST_NRM_W:      if (div_done) state_in = ST_OUT;
         ST_DEN_MUL:    state_in = ST_DEN_ADD;
         ST_DEN_ADD:    state_in = ST_OUT;
         ST_OUT:        if (rsp_load) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         eiu_ff         <= CSR_W'(EIU_RESET);
         items_ff       <= '0;
         stats_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            eiu_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && req_chan.valid && req_op == OP_FINALIZE &&
             items_ff != '0 && limit_in == '0) begin
            stats_ready_ff <= 1'b1;
         end
         if (state_ff == ST_ACC_WR) begin
            items_ff <= items_upd;
         end
         if (state_ff == ST_FIN_SQRT_W && sqrt_done && fin_last) begin
            stats_ready_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_ff     <= req_op;
               el_ff     <= req_chan.element;
               x_ff      <= req_chan.value;
               first_ff  <= req_chan.first_item;
               last_ff   <= req_chan.last_of_item;
               cnt_ff    <= '0;
               sat_ff    <= 1'b0;
               limit_ff  <= limit_in;
               case (req_op)
                  OP_ACCUMULATE: begin
                     res_ff    <= '0;
                     status_ff <= (!req_oob && !req_chan.first_item && items_full)
                                  ? STATUS_SATURATED : STATUS_OK;
                  end
                  OP_FINALIZE: begin
                     res_ff    <= '0;
                     status_ff <= (items_ff == '0) ? STATUS_EMPTY : STATUS_OK;
                  end
                  default: begin
                     if (!req_chan.apply) begin
                        res_ff    <= req_chan.value;
                        status_ff <= STATUS_OK;
                     end else begin
                        res_ff    <= '0;
                        status_ff <= (!stats_ready_ff || req_oob)
                                     ? STATUS_NOT_READY : STATUS_OK;
                     end
                  end
               endcase
            end
         end
         ST_ACC_SQ:     sq_ff  <= x_mag * x_mag;
         ST_FIN_MEAN_S: neg_ff <= sum_rd[SUM_W-1];
         ST_FIN_MEAN_W: begin
            if (div_done) begin
               mean_ff <= mean_sat.value;
               sat_ff  <= sat_ff | mean_sat.sat;
            end
         end
         ST_FIN_E2_S:   msq_ff <= mean_mag * mean_mag;
         ST_FIN_E2_W: begin
            if (div_done) begin
               diff_ff <= e2_diff;
               var_ff  <= SQRT_W'(e2_diff);
            end
         end
         ST_FIN_VAR_W: begin
            if (div_done) begin
               var_ff <= SQRT_W'(diff_ff) + SQRT_W'(div_quo);
            end
         end
         ST_FIN_SQRT_W: begin
            if (sqrt_done) begin
               cnt_ff <= cnt_ff + CW'(1);
               sat_ff <= sat_ff | sd_sat;
               if (fin_last && (sat_ff || sd_sat)) begin
                  status_ff <= STATUS_SATURATED;
               end
            end
         end
         ST_NRM_S:      neg_ff <= nrm_d[VALUE_W];
         ST_NRM_W: begin
            if (div_done) begin
               res_ff <= nrm_sat.value;
               if (nrm_sat.sat) begin
                  status_ff <= STATUS_SATURATED;
               end
            end
         end
         ST_DEN_MUL: begin
            p_ff    <= $signed(x_ff) * $signed({1'b0, mb_sd});
            mean_ff <= mb_mean;
         end
         ST_DEN_ADD: begin
            if (den_total > 39'sd8388607) begin
               res_ff    <= VALUE_MAX;
               status_ff <= STATUS_SATURATED;
            end else if (den_total < -39'sd8388608) begin
               res_ff    <= VALUE_MIN;
               status_ff <= STATUS_SATURATED;
            end else begin
               res_ff <= den_total[VALUE_W-1:0];
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_value_ff  <= res_ff;
               rsp_status_ff <= status_ff;
               rsp_count_ff  <= items_ff;
            end
         end
         default: ;
      endcase
   end

   assign req_chan.ready        = state_ff == ST_IDLE;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.item_count   = rsp_count_ff;
endmodule
